### rtl/deque_with_search_remove_top_defines.svh
// assertion macros for the deque checker
`ifndef DEQUE_WITH_SEARCH_REMOVE_TOP_DEFINES_SVH
`define DEQUE_WITH_SEARCH_REMOVE_TOP_DEFINES_SVH

// condition holds in every checked cycle
`define DEQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/deq_pkg.sv
// shared types and codes for the deque with search and remove
package deq_pkg;

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [KIND_W-1:0]          t_kind;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic [COUNT_W-1:0]         t_count;

    localparam t_kind KIND_PUSH_FRONT = 3'd0;
    localparam t_kind KIND_PUSH_BACK  = 3'd1;
    localparam t_kind KIND_POP_FRONT  = 3'd2;
    localparam t_kind KIND_POP_BACK   = 3'd3;
    localparam t_kind KIND_SEARCH     = 3'd4;
    localparam t_kind KIND_REMOVE     = 3'd5;
    localparam t_kind KIND_CLEAR      = 3'd6;
    localparam t_kind KIND_STATUS     = 3'd7;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_EMPTY     = 2'd1;
    localparam t_status STATUS_FULL      = 2'd2;
    localparam t_status STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic remove;
        logic clear;
    } t_cell_cmd;

endpackage

### rtl/deq_in_if.sv
// input channel: operation kind and data word
interface deq_in_if;
    logic            valid;
    logic            ready;
    deq_pkg::t_kind  kind;
    deq_pkg::t_word  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/deq_out_if.sv
// output channel: per-transaction status and queue snapshot
interface deq_out_if;
    logic              valid;
    logic              ready;
    deq_pkg::t_status  status;
    deq_pkg::t_word    popped_value;
    logic              found;
    deq_pkg::t_count   entry_count;
    deq_pkg::t_word    front_value;
    deq_pkg::t_word    back_value;
    logic              is_empty_flag;

    modport source (output valid, output status, output popped_value, output found,
                    output entry_count, output front_value, output back_value,
                    output is_empty_flag, input ready);
    modport sink   (input valid, input status, input popped_value, input found,
                    input entry_count, input front_value, input back_value,
                    input is_empty_flag, output ready);
endinterface

### rtl/deq_cell.sv
// one storage cell of the shifting deque chain
module deq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  deq_pkg::t_cell_cmd     i_cmd,
    input  logic [DATA_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0]  i_left_value,
    input  logic                   i_left_valid,
    input  logic [DATA_WIDTH-1:0]  i_right_value,
    input  logic                   i_right_valid,
    input  logic                   i_match_before,
    output logic [DATA_WIDTH-1:0]  o_value,
    output logic                   o_valid,
    output logic                   o_match_through,
    output logic [DATA_WIDTH-1:0]  o_tail_value
);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  r_valid;
    logic                  n_valid;
    logic                  w_hit;

    assign w_hit           = r_valid && (r_value == i_key);
    assign o_match_through = i_match_before || w_hit;
    assign o_value         = r_value;
    assign o_valid         = r_valid;
    assign o_tail_value    = (r_valid && !i_right_valid) ? r_value : '0;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.push_front) begin
            n_value = i_left_value;
            n_valid = i_left_valid;
        end else if (i_cmd.push_back) begin
            if (!r_valid && i_left_valid) begin
                n_value = i_key;
                n_valid = 1'b1;
            end
        end else if (i_cmd.pop_front || (i_cmd.remove && o_match_through)) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_cmd.pop_back) begin
            if (!i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

### rtl/deque_with_search_remove_top.sv
// Bounded double-ended queue of DEPTH signed words built as a shifting row of cells, with
// push and pop at either end, search, remove of the first match from the front, clear and
// a status-only operation. One transaction is taken per clock unless input ready is low. On
// acceptance the cell row is updated (all cells compare the key in parallel and shift toward
// the front behind the first match) and the status goes to a pending register; the output
// register then captures it together with count, front and back of the updated row. Input
// ready drops only while a finished result waits and the output side is stalled. Words keep
// their low DATA_WIDTH bits and are sign-extended on output.
module deque_with_search_remove_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    deq_in_if.sink           i_in,
    deq_out_if.source        o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] w_key;
    logic [DATA_WIDTH-1:0] w_value [DEPTH+1];
    logic                  w_valid [DEPTH+1];
    logic                  w_match [DEPTH+1];
    logic [DATA_WIDTH-1:0] w_tail  [DEPTH];
    logic [DATA_WIDTH-1:0] w_back_raw;
    deq_pkg::t_cell_cmd    w_cmd;
    logic                  w_accept;
    logic                  w_load_out;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_any_match;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_pend_valid;
    deq_pkg::t_status      r_pend_status;
    deq_pkg::t_status      n_pend_status;
    deq_pkg::t_word        r_pend_popped;
    deq_pkg::t_word        n_pend_popped;
    logic                  r_pend_found;
    logic                  n_pend_found;

    logic                  r_out_valid;
    deq_pkg::t_status      r_out_status;
    deq_pkg::t_word        r_out_popped;
    logic                  r_out_found;
    deq_pkg::t_count       r_out_count;
    deq_pkg::t_word        r_out_front;
    deq_pkg::t_word        r_out_back;
    logic                  r_out_empty;

    assign w_key       = DATA_WIDTH'($unsigned(i_in.value));
    assign w_full      = w_valid[DEPTH-1];
    assign w_empty     = !w_valid[0];
    assign w_any_match = w_match[DEPTH];

    assign i_in.ready  = !r_pend_valid || !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_load_out  = r_pend_valid && (!r_out_valid || o_out.ready);

    assign w_value[DEPTH] = '0;
    assign w_valid[DEPTH] = 1'b0;
    assign w_match[0]     = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_value;
        logic                  w_left_valid;
        if (g == 0) begin : g_head
            assign w_left_value = w_key;
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
        end
        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (w_cmd),
            .i_key           (w_key),
            .i_left_value    (w_left_value),
            .i_left_valid    (w_left_valid),
            .i_right_value   (w_value[g+1]),
            .i_right_valid   (w_valid[g+1]),
            .i_match_before  (w_match[g]),
            .o_value         (w_value[g]),
            .o_valid         (w_valid[g]),
            .o_match_through (w_match[g+1]),
            .o_tail_value    (w_tail[g])
        );
    end

    always_comb begin
        w_back_raw = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_raw = w_back_raw | w_tail[k];
        end
    end

    always_comb begin
        w_cmd         = '0;
        n_count       = r_count;
        n_pend_status = deq_pkg::STATUS_OK;
        n_pend_popped = '0;
        n_pend_found  = 1'b0;
        unique case (i_in.kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_pend_status = deq_pkg::STATUS_FULL;
                end else begin
                    w_cmd.push_front = w_accept && (i_in.kind == deq_pkg::KIND_PUSH_FRONT);
                    w_cmd.push_back  = w_accept && (i_in.kind == deq_pkg::KIND_PUSH_BACK);
                    n_count          = CNT_W'(r_count + 1'b1);
                end
            end
            deq_pkg::KIND_POP_FRONT: begin
                if (w_empty) begin
                    n_pend_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    w_cmd.pop_front = w_accept;
                    n_pend_popped   = deq_pkg::t_word'($signed(w_value[0]));
                    n_count         = CNT_W'(r_count - 1'b1);
                end
            end
            deq_pkg::KIND_POP_BACK: begin
                if (w_empty) begin
                    n_pend_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    w_cmd.pop_back = w_accept;
                    n_pend_popped  = deq_pkg::t_word'($signed(w_back_raw));
                    n_count        = CNT_W'(r_count - 1'b1);
                end
            end
            deq_pkg::KIND_SEARCH, deq_pkg::KIND_REMOVE: begin
                if (w_empty) begin
                    n_pend_status = deq_pkg::STATUS_EMPTY;
                end else if (w_any_match) begin
                    n_pend_found = 1'b1;
                    if (i_in.kind == deq_pkg::KIND_REMOVE) begin
                        w_cmd.remove = w_accept;
                        n_count      = CNT_W'(r_count - 1'b1);
                    end
                end else begin
                    n_pend_status = deq_pkg::STATUS_NOT_FOUND;
                end
            end
            deq_pkg::KIND_CLEAR: begin
                w_cmd.clear = w_accept;
                n_count     = '0;
            end
            deq_pkg::KIND_STATUS: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count      <= n_count;
                r_pend_valid <= 1'b1;
            end else if (w_load_out) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_pend_status;
            r_pend_popped <= n_pend_popped;
            r_pend_found  <= n_pend_found;
        end
        if (w_load_out) begin
            r_out_status <= r_pend_status;
            r_out_popped <= r_pend_popped;
            r_out_found  <= r_pend_found;
            r_out_count  <= deq_pkg::COUNT_W'(r_count);
            r_out_front  <= w_valid[0] ? deq_pkg::t_word'($signed(w_value[0])) : '0;
            r_out_back   <= deq_pkg::t_word'($signed(w_back_raw));
            r_out_empty  <= !w_valid[0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.popped_value  = r_out_popped;
    assign o_out.found         = r_out_found;
    assign o_out.entry_count   = r_out_count;
    assign o_out.front_value   = r_out_front;
    assign o_out.back_value    = r_out_back;
    assign o_out.is_empty_flag = r_out_empty;

endmodule

### rtl/deq_checker.sv
// port-level checker for the deque top level, with its bind
`include "deque_with_search_remove_top_defines.svh"

module deq_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  deq_pkg::t_status  i_status,
    input  deq_pkg::t_word    i_popped,
    input  logic              i_found,
    input  deq_pkg::t_count   i_count,
    input  deq_pkg::t_word    i_front,
    input  deq_pkg::t_word    i_back,
    input  logic              i_empty
);

    `DEQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_popped) && $stable(i_found) && $stable(i_count) && $stable(i_front) && $stable(i_back) && $stable(i_empty), "stalled output transaction changed")
    `DEQ_ASSERT_SAME(a_empty_count, i_out_valid, i_empty == (i_count == '0), "empty flag disagrees with entry count")
    `DEQ_ASSERT_SAME(a_empty_ends, i_out_valid && i_empty, i_front == '0 && i_back == '0, "empty queue shows nonzero front or back")
    `DEQ_ASSERT_SAME(a_found_ok, i_out_valid && i_found, i_status == deq_pkg::STATUS_OK && i_popped == '0, "found flag with non-ok status or popped word")

endmodule

bind deque_with_search_remove_top deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_popped    (o_out.popped_value),
    .i_found     (o_out.found),
    .i_count     (o_out.entry_count),
    .i_front     (o_out.front_value),
    .i_back      (o_out.back_value),
    .i_empty     (o_out.is_empty_flag)
);

### verif/deque_with_search_remove_top_test.sv
// self-checking testbench for the deque with search and remove
module deque_with_search_remove_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_OPS   = 1130;
    localparam int TAIL_OPS     = 120;
    localparam int LONG_HOLD    = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;

    localparam deq_pkg::t_kind KIND_ORDER [8] = '{deq_pkg::KIND_PUSH_FRONT,
        deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK,
        deq_pkg::KIND_SEARCH, deq_pkg::KIND_REMOVE, deq_pkg::KIND_CLEAR,
        deq_pkg::KIND_STATUS};
    // cumulative percentages per kind: fill-heavy, drain-heavy, mixed
    localparam int KIND_CUM [3][8] = '{
        '{40, 75, 83, 88, 93, 97, 98, 100},
        '{10, 20, 45, 70, 80, 95, 97, 100},
        '{20, 40, 52, 64, 76, 90, 93, 100}};

    typedef struct {
        deq_pkg::t_kind kind;
        deq_pkg::t_word value;
        bit             wait_idle;
        bit             hold_sink;
    } t_op;

    typedef struct {
        deq_pkg::t_status status;
        deq_pkg::t_word   popped;
        logic             found;
        deq_pkg::t_count  count;
        deq_pkg::t_word   front;
        deq_pkg::t_word   back;
        logic             empty;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    deque_with_search_remove_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (deq_pkg::WORD_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_op            op_queue [$];
    t_outcome       pending_outcomes [$];
    deq_pkg::t_word stored_words [$];
    deq_pkg::t_word word_pool [8];

    int  sent_count = 0;
    int  done_count = 0;
    int  errors = 0;
    int  cycles = 0;
    bit  hold_req = 1'b0;
    bit  tail_part = 1'b0;
    int  src_gap = 0;
    int  src_calm = 0;
    int  sink_hold = 0;
    int  sink_stall = 0;
    int  sink_calm = 0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    function automatic void add_op(deq_pkg::t_kind kind, deq_pkg::t_word value,
                                   bit wait_idle, bit hold_sink);
        t_op op;
        op.kind = kind;
        op.value = value;
        op.wait_idle = wait_idle;
        op.hold_sink = hold_sink;
        op_queue.push_back(op);
    endfunction

    function automatic t_outcome deque_next_outcome(deq_pkg::t_kind kind,
                                                    deq_pkg::t_word w);
        t_outcome r;
        int idx;
        r.status = deq_pkg::STATUS_OK;
        r.popped = '0;
        r.found = 1'b0;
        idx = -1;
        case (kind)
            deq_pkg::KIND_PUSH_FRONT: begin
                if (stored_words.size() >= DEPTH) r.status = deq_pkg::STATUS_FULL;
                else stored_words.push_front(w);
            end
            deq_pkg::KIND_PUSH_BACK: begin
                if (stored_words.size() >= DEPTH) r.status = deq_pkg::STATUS_FULL;
                else stored_words.push_back(w);
            end
            deq_pkg::KIND_POP_FRONT: begin
                if (stored_words.size() == 0) r.status = deq_pkg::STATUS_EMPTY;
                else r.popped = stored_words.pop_front();
            end
            deq_pkg::KIND_POP_BACK: begin
                if (stored_words.size() == 0) r.status = deq_pkg::STATUS_EMPTY;
                else r.popped = stored_words.pop_back();
            end
            deq_pkg::KIND_SEARCH, deq_pkg::KIND_REMOVE: begin
                if (stored_words.size() == 0) begin
                    r.status = deq_pkg::STATUS_EMPTY;
                end else begin
                    for (int i = 0; i < stored_words.size(); i++) begin
                        if (idx < 0 && stored_words[i] == w) idx = i;
                    end
                    if (idx < 0) begin
                        r.status = deq_pkg::STATUS_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        if (kind == deq_pkg::KIND_REMOVE) stored_words.delete(idx);
                    end
                end
            end
            deq_pkg::KIND_CLEAR: stored_words.delete();
            default: ;
        endcase
        r.count = deq_pkg::t_count'(stored_words.size());
        r.empty = (stored_words.size() == 0);
        r.front = r.empty ? deq_pkg::t_word'(0) : stored_words[0];
        r.back  = r.empty ? deq_pkg::t_word'(0) : stored_words[$];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // source side
    always @(posedge i_clk) begin : drive
        logic fire;
        logic nxt_valid;
        logic nxt_hold;
        logic skip;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            fire = in_ch.valid && in_ch.ready;
            nxt_valid = in_ch.valid && !fire;
            nxt_hold = 1'b0;
            skip = 1'b0;
            if (fire) void'(op_queue.pop_front());
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (op_queue.size() != 0 && !(op_queue[0].wait_idle &&
                             (fire || sent_count != done_count))) begin
                    if (!tail_part && src_calm > 0) begin
                        src_calm--;
                    end else if (!tail_part && $urandom_range(0, 39) == 0) begin
                        src_calm = $urandom_range(20, 60);
                    end else if (!tail_part && $urandom_range(0, 4) == 0) begin
                        src_gap = $urandom_range(0, 4);
                        skip = 1'b1;
                    end
                    if (!skip) begin
                        in_ch.kind <= op_queue[0].kind;
                        in_ch.value <= op_queue[0].value;
                        nxt_valid = 1'b1;
                        nxt_hold = op_queue[0].hold_sink;
                    end
                end
            end
            in_ch.valid <= nxt_valid;
            hold_req <= nxt_hold;
            tail_part <= (op_queue.size() <= TAIL_OPS);
        end
    end

    // sink side
    always @(posedge i_clk) begin : sink_side
        logic nxt_ready;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            nxt_ready = 1'b1;
            if (hold_req) sink_hold = LONG_HOLD;
            if (sink_hold > 0) begin
                sink_hold--;
                nxt_ready = 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                nxt_ready = 1'b0;
            end else if (tail_part) begin
                nxt_ready = 1'b1;
            end else if (sink_calm > 0) begin
                sink_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                sink_calm = $urandom_range(20, 60);
            end else if ($urandom_range(0, 4) == 0) begin
                sink_stall = $urandom_range(0, 4);
                nxt_ready = 1'b0;
            end
            out_ch.ready <= nxt_ready;
        end
    end

    // prediction on input transactions, comparison on output transactions
    always @(posedge i_clk) begin : score
        t_outcome want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("popped_value", want.popped, out_ch.popped_value);
                    check_field("found", want.found, out_ch.found);
                    check_field("entry_count", want.count, out_ch.entry_count);
                    check_field("front_value", want.front, out_ch.front_value);
                    check_field("back_value", want.back, out_ch.back_value);
                    check_field("is_empty_flag", want.empty, out_ch.is_empty_flag);
                end
                done_count <= done_count + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_outcomes.push_back(deque_next_outcome(in_ch.kind, in_ch.value));
                sent_count <= sent_count + 1;
            end
        end
    end

    initial begin
        int n;
        int mode;
        int seg_len;
        int r;
        deq_pkg::t_kind k;
        deq_pkg::t_word v;

        in_ch.valid = 1'b0;
        in_ch.kind = deq_pkg::KIND_STATUS;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        word_pool[0] = 32'sh8000_0000;
        word_pool[1] = 32'sh7fff_ffff;
        word_pool[2] = -32'sd1;
        word_pool[3] = 32'sd0;
        for (int i = 4; i < 8; i++) word_pool[i] = deq_pkg::t_word'($urandom);

        // empty cases, extremes, duplicates, hit and miss, clear
        add_op(deq_pkg::KIND_STATUS, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_POP_BACK, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_SEARCH, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_REMOVE, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_BACK, 32'sh7fff_ffff, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_FRONT, -32'sd1, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_BACK, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_BACK, 32'sh7fff_ffff, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_SEARCH, 32'sh7fff_ffff, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_SEARCH, 32'sd5, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_REMOVE, 32'sh7fff_ffff, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_REMOVE, 32'sd12345, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_POP_BACK, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_STATUS, -32'sd1, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_CLEAR, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_STATUS, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_POP_BACK, 32'sd0, 1'b0, 1'b0);
        add_op(deq_pkg::KIND_PUSH_BACK, 32'sd1, 1'b1, 1'b0);

        n = 0;
        while (n < RANDOM_OPS) begin
            mode = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 40);
            for (int j = 0; j < seg_len && n < RANDOM_OPS; j++) begin
                r = $urandom_range(0, 99);
                k = deq_pkg::KIND_STATUS;
                for (int m = 7; m >= 0; m--) begin
                    if (r < KIND_CUM[mode][m]) k = KIND_ORDER[m];
                end
                v = ($urandom_range(0, 9) < 7) ? word_pool[$urandom_range(0, 7)]
                                                : deq_pkg::t_word'($urandom);
                add_op(k, v, (n % 170) == 169, n == 200 || n == 600 || n == 900);
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((op_queue.size() != 0 || sent_count != done_count) && cycles < CYCLE_LIMIT)
            @(posedge i_clk);

        if (cycles >= CYCLE_LIMIT) begin
            $display("[deque_with_search_remove_top] ERROR");
        end else begin
            repeat (SETTLE) @(posedge i_clk);
            if (pending_outcomes.size() != 0) begin
                $error("%0d expected results never arrived", pending_outcomes.size());
                errors++;
            end
            if (errors == 0) begin
                $display("[deque_with_search_remove_top] OK");
            end else begin
                $display("[deque_with_search_remove_top] ERROR");
            end
        end
        $finish;
    end

endmodule
